/* sv/rtos_delay_timer_queue_defines.svh */
// Assertion macros shared by the delay timer queue RTL.
`ifndef RTOS_DELAY_TIMER_QUEUE_DEFINES_SVH
`define RTOS_DELAY_TIMER_QUEUE_DEFINES_SVH

// Check on every clock edge once reset has been released.
`define RDTQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check on every clock edge, including edges while reset is held.
`define RDTQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/rdtq_pkg.sv */
// Shared types, codes and constants for the delay timer queue.
`default_nettype none

package rdtq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_W          = 48;
    localparam int LO_W            = 32;
    localparam int TASK_W          = 8;
    localparam int DELAY_W         = 32;
    localparam int INC_W           = 16;
    localparam int MAX_WAKE        = 16;
    localparam int WAKE_CNT_W      = 5;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [TASK_W-1:0] tid_t;

    typedef struct packed {
        time_t wake_time;
        tid_t  task_id;
    } entry_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_DELAY = 2'd1,
        ACT_SET   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_NO_WAKE = 3'd0,
        KIND_WOKEN   = 3'd1,
        KIND_QUEUED  = 3'd2,
        KIND_REJECT  = 3'd3,
        KIND_SET     = 3'd4,
        KIND_FULL    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_ADD,
        ST_WAKE_RD,
        ST_WAKE_CMP,
        ST_DLY_ADD,
        ST_INS_RD,
        ST_INS_CMP,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* sv/rdtq_alu.sv */
// Shared time unit: 48-bit add with low-word carry, and unsigned greater-than.
`default_nettype none

module rdtq_alu (
    input  rdtq_pkg::time_t a,
    input  rdtq_pkg::time_t b,
    output rdtq_pkg::time_t sum,
    output logic            gt
);

    localparam int HI_W = rdtq_pkg::TIME_W - rdtq_pkg::LO_W;

    logic [rdtq_pkg::LO_W:0] lo_sum;
    logic [HI_W-1:0]         hi_sum;

    // only the low word of b is an addend; carry ripples into the high word
    assign lo_sum = {1'b0, a[rdtq_pkg::LO_W-1:0]} + {1'b0, b[rdtq_pkg::LO_W-1:0]};
    assign hi_sum = a[rdtq_pkg::TIME_W-1:rdtq_pkg::LO_W] + HI_W'(lo_sum[rdtq_pkg::LO_W]);
    assign sum    = {hi_sum, lo_sum[rdtq_pkg::LO_W-1:0]};
    assign gt     = (a > b);

endmodule

`default_nettype wire

/* sv/rdtq_store.sv */
// Queue entry memory: one write port, one registered read port.
`default_nettype none

module rdtq_store #(
    parameter  int DEPTH = rdtq_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               clk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  rdtq_pkg::entry_t   wdata,
    input  logic [IDX_W-1:0]   raddr,
    output rdtq_pkg::entry_t   rdata
);

    rdtq_pkg::entry_t mem [DEPTH];
    rdtq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/rtos_delay_timer_queue.sv */
// Top level: 48-bit system clock with a wake-time sorted delay queue.
//
//  channel | dir | handshake          | payload
//  cfg     | in  | cfg_valid/ready    | cfg_data: tick increment
//  s       | in  | s_tvalid/tready    | s_tuser: action; s_tdata: task, delay, time
//  m       | out | m_tvalid/tready    | m_tuser: kind, full; m_tdata: task, time
//
//  One word is in flight at a time; all time math goes through one shared adder/comparator.
//  Set-time, rejected delay and full-queue delay go straight to the emit state.
//  Tick: add the increment, then compare the head entry and wake it, repeated until a
//  later wake time, an empty queue or MAX_WAKE woken tasks. Delay: add the delay, then walk
//  back from the tail, moving each later entry up one slot, until a compare or the head ends the walk.
//  A full output register stalls the sequencer until m_tready; rst_n clears
//  the clock, the queue count and the tick increment (back to 1) at once.
`default_nettype none
`include "rtos_delay_timer_queue_defines.svh"

module rtos_delay_timer_queue #(
    parameter int QUEUE_DEPTH = rdtq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // task_id[7:0], delay[39:8], new_time[87:40]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // task_id_res[7:0], current_time[55:8]
    output logic [3:0]  m_tuser,   // kind[2:0], queue_full[3]
    output logic        m_tlast
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int NW    = rdtq_pkg::WAKE_CNT_W;

    // physical slot of a logical queue position, ring starting at head
    function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    rdtq_pkg::state_t state_reg, state_next;
    rdtq_pkg::time_t  clock_reg, clock_next;
    rdtq_pkg::time_t  wake_reg, wake_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             pend_reg, pend_next;
    rdtq_pkg::kind_t  res_kind_reg, res_kind_next;
    rdtq_pkg::tid_t   res_task_reg, res_task_next;
    logic [30:0]      delay_reg, delay_next;
    logic [rdtq_pkg::INC_W-1:0] inc_reg;

    logic             m_tvalid_reg;
    rdtq_pkg::kind_t  m_kind_reg;
    rdtq_pkg::tid_t   m_task_reg;
    rdtq_pkg::time_t  m_time_reg;
    logic             m_last_reg;

    logic             out_free;
    logic             out_load;
    rdtq_pkg::kind_t  out_kind;
    rdtq_pkg::tid_t   out_task;
    logic             out_last;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    rdtq_pkg::entry_t mem_wdata;
    rdtq_pkg::entry_t mem_rdata;

    rdtq_pkg::time_t  alu_a, alu_b, alu_sum;
    logic             alu_gt;

    rdtq_pkg::action_t in_action;
    rdtq_pkg::tid_t    in_task;
    logic [rdtq_pkg::DELAY_W-1:0] in_delay;
    rdtq_pkg::time_t   in_time;
    logic [IDX_W-1:0]  head_adv;

    logic             at_wake_cmp;
    logic             at_count_step;
    logic             at_clock_step;

    assign in_action = rdtq_pkg::action_t'(s_tuser);
    assign in_task   = s_tdata[7:0];
    assign in_delay  = s_tdata[39:8];
    assign in_time   = s_tdata[87:40];

    assign head_adv  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    rdtq_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .gt  (alu_gt)
    );

    rdtq_store #(
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdtq_pkg::ST_IDLE;
            clock_reg <= '0;
            count_reg <= '0;
            head_reg  <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            inc_reg   <= rdtq_pkg::INC_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            clock_reg <= clock_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                inc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wake_reg     <= wake_next;
        res_kind_reg <= res_kind_next;
        res_task_reg <= res_task_next;
        delay_reg    <= delay_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        clock_next    = clock_reg;
        wake_next     = wake_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        head_next     = head_reg;
        n_next        = n_reg;
        pend_next     = pend_reg;
        res_kind_next = res_kind_reg;
        res_task_next = res_task_reg;
        delay_next    = delay_reg;
        mem_we        = 1'b0;
        mem_waddr     = head_reg;
        mem_raddr     = head_reg;
        mem_wdata     = '{wake_time: wake_reg, task_id: res_task_reg};
        alu_a         = clock_reg;
        alu_b         = '0;
        out_load      = 1'b0;
        out_kind      = res_kind_reg;
        out_task      = res_task_reg;
        out_last      = 1'b1;

        unique case (state_reg)
            rdtq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_action)
                        rdtq_pkg::ACT_TICK:
                        begin
                            state_next = rdtq_pkg::ST_TICK_ADD;
                        end
                        rdtq_pkg::ACT_DELAY:
                        begin
                            res_task_next = in_task;
                            delay_next    = in_delay[30:0];
                            if (in_delay[rdtq_pkg::DELAY_W-1])
                            begin
                                res_kind_next = rdtq_pkg::KIND_REJECT;
                                res_task_next = '0;
                                state_next    = rdtq_pkg::ST_EMIT;
                            end
                            else if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                res_kind_next = rdtq_pkg::KIND_FULL;
                                res_task_next = '0;
                                state_next    = rdtq_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = rdtq_pkg::ST_DLY_ADD;
                            end
                        end
                        rdtq_pkg::ACT_SET:
                        begin
                            clock_next    = in_time;
                            res_kind_next = rdtq_pkg::KIND_SET;
                            res_task_next = '0;
                            state_next    = rdtq_pkg::ST_EMIT;
                        end
                        rdtq_pkg::ACT_NONE:
                        begin
                            state_next = rdtq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            rdtq_pkg::ST_TICK_ADD:
            begin
                alu_b      = rdtq_pkg::time_t'(inc_reg);
                clock_next = alu_sum;
                n_next     = '0;
                pend_next  = 1'b0;
                state_next = rdtq_pkg::ST_WAKE_RD;
            end

            rdtq_pkg::ST_WAKE_RD:
            begin
                if (count_reg != '0 && n_reg != NW'(rdtq_pkg::MAX_WAKE))
                begin
                    state_next = rdtq_pkg::ST_WAKE_CMP;
                end
                else
                begin
                    res_kind_next = pend_reg ? rdtq_pkg::KIND_WOKEN : rdtq_pkg::KIND_NO_WAKE;
                    res_task_next = pend_reg ? res_task_reg : '0;
                    state_next    = rdtq_pkg::ST_EMIT;
                end
            end

            rdtq_pkg::ST_WAKE_CMP:
            begin
                alu_a = mem_rdata.wake_time;
                alu_b = clock_reg;
                if (alu_gt)
                begin
                    res_kind_next = pend_reg ? rdtq_pkg::KIND_WOKEN : rdtq_pkg::KIND_NO_WAKE;
                    res_task_next = pend_reg ? res_task_reg : '0;
                    state_next    = rdtq_pkg::ST_EMIT;
                end
                else if (!pend_reg || out_free)
                begin
                    // release the previous wake as non-final, hold this one back
                    out_load      = pend_reg;
                    out_kind      = rdtq_pkg::KIND_WOKEN;
                    out_last      = 1'b0;
                    res_task_next = mem_rdata.task_id;
                    pend_next     = 1'b1;
                    head_next     = head_adv;
                    count_next    = count_reg - 1'b1;
                    n_next        = n_reg + 1'b1;
                    state_next    = rdtq_pkg::ST_WAKE_RD;
                end
            end

            rdtq_pkg::ST_DLY_ADD:
            begin
                alu_b      = rdtq_pkg::time_t'(delay_reg);
                wake_next  = alu_sum;
                k_next     = count_reg;
                state_next = rdtq_pkg::ST_INS_RD;
            end

            rdtq_pkg::ST_INS_RD:
            begin
                if (k_reg == '0)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = phys_idx(head_reg, k_reg);
                    count_next    = count_reg + 1'b1;
                    res_kind_next = rdtq_pkg::KIND_QUEUED;
                    state_next    = rdtq_pkg::ST_EMIT;
                end
                else
                begin
                    mem_raddr  = phys_idx(head_reg, k_reg - 1'b1);
                    state_next = rdtq_pkg::ST_INS_CMP;
                end
            end

            rdtq_pkg::ST_INS_CMP:
            begin
                alu_a     = mem_rdata.wake_time;
                alu_b     = wake_reg;
                mem_we    = 1'b1;
                mem_waddr = phys_idx(head_reg, k_reg);
                if (alu_gt)
                begin
                    // later entry moves up one slot
                    mem_wdata  = mem_rdata;
                    k_next     = k_reg - 1'b1;
                    state_next = rdtq_pkg::ST_INS_RD;
                end
                else
                begin
                    count_next    = count_reg + 1'b1;
                    res_kind_next = rdtq_pkg::KIND_QUEUED;
                    state_next    = rdtq_pkg::ST_EMIT;
                end
            end

            rdtq_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = rdtq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rdtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_kind_reg <= out_kind;
            m_task_reg <= out_task;
            m_time_reg <= clock_reg;
            m_last_reg <= out_last;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == rdtq_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_time_reg, m_task_reg};
    assign m_tuser   = {(m_kind_reg == rdtq_pkg::KIND_FULL), m_kind_reg};
    assign m_tlast   = m_last_reg;

    assign at_wake_cmp   = (state_reg == rdtq_pkg::ST_WAKE_CMP);
    assign at_count_step = at_wake_cmp || (state_reg == rdtq_pkg::ST_INS_RD) ||
                           (state_reg == rdtq_pkg::ST_INS_CMP);
    assign at_clock_step = (state_reg == rdtq_pkg::ST_TICK_ADD) ||
                           (state_reg == rdtq_pkg::ST_IDLE);

    `RDTQ_ASSERT_ALWAYS(a_count_bound, !rst_n || count_reg <= CNT_W'(QUEUE_DEPTH), "count high")
    `RDTQ_ASSERT(a_head_step, (head_reg != $past(head_reg)) |-> $past(at_wake_cmp), "head moved")
    `RDTQ_ASSERT(a_count_src, (count_reg != $past(count_reg)) |-> $past(at_count_step), "bad count")
    `RDTQ_ASSERT(a_clock_src, (clock_reg != $past(clock_reg)) |-> $past(at_clock_step), "bad clock")
    `RDTQ_ASSERT(a_wake_limit, n_reg <= NW'(rdtq_pkg::MAX_WAKE), "too many wakes in one tick")

endmodule

`default_nettype wire

/* sim/rdtq_tb_pkg.sv */
// Scoreboard for the delay timer queue: clock, sorted wait queue and expected words.
`timescale 1ns / 100ps

package rdtq_tb_pkg;

    import rdtq_pkg::*;

    typedef struct {
        kind_t kind;
        tid_t  task_id;
        time_t now;
        logic  full;
        logic  last;
    } wake_word_t;

    class wake_predictor;

        time_t       clock_now;
        logic [15:0] increment;
        time_t       wake_at [QUEUE_DEPTH_DEF];
        tid_t        sleeper [QUEUE_DEPTH_DEF];
        int unsigned sleepers;
        wake_word_t  expected_words[$];

        int unsigned mismatches;
        int unsigned items_taken;
        int unsigned words_checked;
        int unsigned wakes;
        int unsigned drops;
        int unsigned rejects;
        int unsigned peak_wakes;

        function new();
            clock_now     = '0;
            increment     = 16'd1;
            sleepers      = 0;
            mismatches    = 0;
            items_taken   = 0;
            words_checked = 0;
            wakes         = 0;
            drops         = 0;
            rejects       = 0;
            peak_wakes    = 0;
        endfunction

        function void set_increment(logic [15:0] value);
            increment = value;
        endfunction

        function void push_word(kind_t kind, tid_t tid, logic full, logic last);
            wake_word_t w;
            w.kind    = kind;
            w.task_id = tid;
            w.now     = clock_now;
            w.full    = full;
            w.last    = last;
            expected_words.push_back(w);
            if (kind == KIND_WOKEN)
                wakes++;
            else if (kind == KIND_FULL)
                drops++;
            else if (kind == KIND_REJECT)
                rejects++;
        endfunction

        // Advance the clock and queue for one accepted input word.
        function void accept_item(action_t act, tid_t tid, logic [31:0] dly, time_t new_time);
            int unsigned due;
            int unsigned pos;
            int unsigned i;
            time_t       wake;
            items_taken++;
            case (act)
                ACT_TICK:
                begin
                    clock_now = clock_now + {32'd0, increment};
                    due = 0;
                    while (due < sleepers && due < MAX_WAKE && wake_at[due] <= clock_now)
                        due++;
                    if (due == 0)
                        push_word(KIND_NO_WAKE, '0, 1'b0, 1'b1);
                    for (i = 0; i < due; i++)
                        push_word(KIND_WOKEN, sleeper[i], 1'b0, i == due - 1);
                    // drop the woken entries from the head
                    for (i = due; i < sleepers; i++)
                    begin
                        wake_at[i - due] = wake_at[i];
                        sleeper[i - due] = sleeper[i];
                    end
                    sleepers = sleepers - due;
                    if (due > peak_wakes)
                        peak_wakes = due;
                end
                ACT_DELAY:
                begin
                    if (dly[31])
                        push_word(KIND_REJECT, '0, 1'b0, 1'b1);
                    else if (sleepers >= QUEUE_DEPTH_DEF)
                        push_word(KIND_FULL, '0, 1'b1, 1'b1);
                    else
                    begin
                        wake = clock_now + {16'd0, dly};
                        // insert behind every entry due at or before this one
                        pos = sleepers;
                        while (pos > 0 && wake_at[pos - 1] > wake)
                            pos--;
                        for (i = sleepers; i > pos; i--)
                        begin
                            wake_at[i] = wake_at[i - 1];
                            sleeper[i] = sleeper[i - 1];
                        end
                        wake_at[pos] = wake;
                        sleeper[pos] = tid;
                        sleepers++;
                        push_word(KIND_QUEUED, tid, 1'b0, 1'b1);
                    end
                end
                ACT_SET:
                begin
                    clock_now = new_time;
                    push_word(KIND_SET, '0, 1'b0, 1'b1);
                end
                ACT_NONE: ;
            endcase
        endfunction

        function void check_word(logic [55:0] data, logic [3:0] user, logic last);
            wake_word_t want;
            logic [2:0] got_kind;
            tid_t       got_tid;
            time_t      got_now;
            logic       got_full;
            got_tid  = data[7:0];
            got_now  = data[55:8];
            got_kind = user[2:0];
            got_full = user[3];
            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %0d: kind %0d task %0d time %h full %0b last %0b",
                             words_checked, got_kind, got_tid, got_now, got_full, last);
                return;
            end
            want = expected_words.pop_front();
            if (got_kind !== want.kind || got_tid !== want.task_id || got_now !== want.now ||
                got_full !== want.full || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("word %0d mismatch: expected kind %0d task %0d time %h full %0b last %0b",
                             words_checked, want.kind, want.task_id, want.now, want.full,
                             want.last);
                    $display("                   got      kind %0d task %0d time %h full %0b last %0b",
                             got_kind, got_tid, got_now, got_full, last);
                end
            end
        endfunction

    endclass

endpackage

/* sim/tb_top.sv */
// Top-level testbench for the delay timer queue: stimulus, result sink and verdict.
`timescale 1ns / 100ps

module tb_top;

    import rdtq_pkg::*;
    import rdtq_tb_pkg::*;

    // longest insert walk plus margin
    localparam int    HOLD_OFF = 2 * QUEUE_DEPTH_DEF + 16;
    localparam time_t TIME_MAX = '1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // task_id[7:0], delay[39:8], new_time[87:40]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // task_id_res[7:0], current_time[55:8]
    logic [3:0]  m_tuser;   // kind[2:0], queue_full[3]
    logic        m_tlast;

    bit            no_idle;
    int            cfg_writes;
    wake_predictor queue_model;

    rtos_delay_timer_queue dut (.*);

    always #5 clk = ~clk;

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [31:0] pick_delay();
        int span;
        span = 4 * int'(queue_model.increment);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom();
            2: return $urandom() | 32'h8000_0000;
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, span);
        endcase
    endfunction

    // flush: land the next tick on the top of the clock so the whole queue wakes
    function automatic time_t pick_time(bit flush);
        int          span;
        logic [31:0] hi;
        logic [31:0] lo;
        span = 4 * int'(queue_model.increment);
        hi   = $urandom();
        lo   = $urandom();
        if (flush)
            return TIME_MAX - {32'd0, queue_model.increment};
        case ($urandom_range(0, 2))
            0: return {hi[15:0], lo};
            1: return TIME_MAX - 48'($urandom_range(0, span));
            default: return {hi[15:0], 32'hFFFF_FFFF - 32'($urandom_range(0, span))};
        endcase
    endfunction

    task automatic send_word(input action_t act, input tid_t tid, input logic [31:0] dly,
                             input time_t new_time);
        int gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {new_time, dly, tid};
        do @(posedge clk); while (!s_tready);
        queue_model.accept_item(act, tid, dly, new_time);
    endtask

    // Hold the sender until every expected word is back and the block has gone quiet.
    task automatic settle_block();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (queue_model.expected_words.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_increment(input logic [15:0] value);
        settle_block();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        queue_model.set_increment(value);
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Clock wrap, carry, rejects, a full queue with ties and wrapped wake times,
    // then one tick that wakes all sixteen.
    task automatic run_directed();
        int          i;
        tid_t        tid;
        logic [31:0] dly;
        send_word(ACT_SET, 8'h00, 32'd0, TIME_MAX - 1);
        send_word(ACT_TICK, 8'hFF, 32'hFFFF_FFFF, TIME_MAX);
        send_word(ACT_TICK, 8'h00, 32'd0, '0);
        send_word(ACT_DELAY, 8'hFF, 32'h8000_0000, TIME_MAX);
        send_word(ACT_DELAY, 8'h00, 32'hFFFF_FFFF, '0);
        send_word(ACT_NONE, 8'h5A, 32'h1234_5678, 48'hA5A5_5A5A_0F0F);
        send_word(ACT_SET, 8'h00, 32'd0, TIME_MAX - 15);
        for (i = 0; i < QUEUE_DEPTH_DEF; i++)
        begin
            tid = 8'(i * 17);
            if (i == 5)
                tid = 8'd68;   // same task queued twice
            case (i % 4)
                0: dly = 32'h20;
                1: dly = 32'd0;
                2: dly = 32'h7FFF_FFFF;
                default: dly = 32'd5;
            endcase
            send_word(ACT_DELAY, tid, dly, '0);
        end
        send_word(ACT_DELAY, 8'hAA, 32'd1, '0);
        send_word(ACT_SET, 8'h00, 32'd0, TIME_MAX - 1);
        send_word(ACT_TICK, 8'h00, 32'd0, '0);
        send_word(ACT_SET, 8'hFF, 32'hFFFF_FFFF, '0);
    endtask

    // Stretches of fill, drain or mixed traffic with random content.
    task automatic run_random(input int quota);
        int      done;
        int      left;
        int      mode;
        int      roll;
        action_t act;
        done = 0;
        left = 0;
        mode = 0;
        while (done < quota)
        begin
            if (left == 0)
            begin
                left    = $urandom_range(6, 24);
                mode    = $urandom_range(0, 2);
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 7) == 0)
                    settle_block();
            end
            roll = $urandom_range(0, 99);
            case (mode)
                0: act = roll < 70 ? ACT_DELAY : roll < 90 ? ACT_TICK :
                         roll < 96 ? ACT_SET : ACT_NONE;
                1: act = roll < 20 ? ACT_DELAY : roll < 90 ? ACT_TICK :
                         roll < 97 ? ACT_SET : ACT_NONE;
                default: act = roll < 45 ? ACT_DELAY : roll < 80 ? ACT_TICK :
                               roll < 94 ? ACT_SET : ACT_NONE;
            endcase
            send_word(act, tid_t'($urandom()), pick_delay(),
                      pick_time(mode == 1 && $urandom_range(0, 2) != 0));
            if (act != ACT_NONE)
                done++;
            left--;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_cycles();
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            queue_model.check_word(m_tdata, m_tuser, m_tlast);
        end
    end

    initial
    begin : stimulus
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_TICK;
        cfg_valid   = 1'b0;
        cfg_data    = 16'd0;
        no_idle     = 1'b0;
        cfg_writes  = 0;
        queue_model = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_increment(16'd1);
        run_directed();
        write_increment(16'hFFFF);
        run_random(60);
        write_increment(16'($urandom_range(2, 16'hFFFE)));
        run_random(60);
        write_increment(16'd1);
        run_random(60);
        write_increment(16'($urandom_range(2, 300)));
        run_random(60);
        settle_block();

        $display("covered %0d input words, %0d result words, %0d increment settings",
                 queue_model.items_taken, queue_model.words_checked, cfg_writes);
        $display("  %0d wakes (peak %0d in one tick), %0d full drops, %0d rejects, %0d mismatches",
                 queue_model.wakes, queue_model.peak_wakes, queue_model.drops,
                 queue_model.rejects, queue_model.mismatches);
        if (queue_model.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("timeout with %0d words outstanding", queue_model.expected_words.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
